// ----- rtl/alc_pkg.sv -----
`default_nettype none

package alc_pkg;

   // Field widths
   localparam int RAW_W      = 16;
   localparam int LUX_W      = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   // Fixed-point layout
   localparam int SCALE_FRAC = 10;
   localparam int GAIN_SHIFT = 4;
   localparam int BASE_W     = 15;
   localparam int SCALE_W    = BASE_W + GAIN_SHIFT;
   localparam int SC_W       = 32 - SCALE_FRAC;
   localparam int RATIO_SH   = 10;
   localparam int DIVD_W     = SC_W + RATIO_SH;
   localparam int Q_W        = 11;
   localparam int COEF_W     = 10;
   localparam int SEG_W      = 3;
   localparam int PROD_W     = SC_W + COEF_W;
   localparam int LUX_FRAC   = 14;

   localparam logic [RAW_W-1:0]  COUNT_FULL  = 16'hFFFF;
   localparam logic [BASE_W-1:0] SCALE_13MS  = 15'h7517;
   localparam logic [BASE_W-1:0] SCALE_101MS = 15'h0FE7;
   localparam logic [BASE_W-1:0] SCALE_UNITY = 15'h0400;
   localparam logic [PROD_W-1:0] LUX_ROUND   = 32'h0000_2000;

   // Integration codes
   localparam logic [1:0] INTEG_13MS  = 2'd0;
   localparam logic [1:0] INTEG_101MS = 2'd1;
   localparam logic [1:0] INTEG_402MS = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PKG   = 2'd2;

   localparam logic [SEG_W-1:0] SEG_LAST = 3'd7;

   localparam logic [COEF_W-1:0] KNEE_TAB [2][8] = '{
      '{10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A, 10'h29A},
      '{10'h043, 10'h085, 10'h0C8, 10'h10A, 10'h14D, 10'h19A, 10'h29A, 10'h29A}
   };
   localparam logic [COEF_W-1:0] BASE_TAB [2][8] = '{
      '{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000},
      '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
   };
   localparam logic [COEF_W-1:0] SLOPE_TAB [2][8] = '{
      '{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000},
      '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B, 10'h000}
   };

   typedef struct packed {
      logic [1:0] integ_sel;
      logic       gain_16x;
      logic       pkg_cs;
   } alc_cfg_type;

   typedef struct packed {
      logic            sat;
      logic [SC_W-1:0] c0;
      logic [SC_W-1:0] c1;
   } alc_scaled_type;

   typedef struct packed {
      logic              sat;
      logic              big;
      logic              zero;
      logic [DIVD_W-1:0] rem;
      logic [Q_W-1:0]    quot;
      logic [SC_W-1:0]   c0;
      logic [SC_W-1:0]   c1;
   } alc_div_stage_type;

   typedef struct packed {
      logic              sat;
      logic [SC_W-1:0]   c0;
      logic [SC_W-1:0]   c1;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] m;
   } alc_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } alc_q_stat_type;

   // First knee at or above the ratio; a ratio past every knee takes the last segment.
   function automatic logic [SEG_W-1:0] alc_segment(logic pkg, logic big,
                                                    logic [Q_W-1:0] ratio);
      logic [SEG_W-1:0] seg;
      seg = SEG_LAST;
      for (int k = 6; k >= 0; k--) begin
         if (ratio <= Q_W'(KNEE_TAB[pkg][k])) begin
            seg = SEG_W'(k);
         end
      end
      if (big) begin
         seg = SEG_LAST;
      end
      return seg;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/alc_ratio_div.sv -----
`default_nettype none

module alc_ratio_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  alc_pkg::alc_scaled_type    in_data,
   output logic                       out_valid,
   output alc_pkg::alc_div_stage_type out_stage
);
   import alc_pkg::*;

   localparam int STAGES = Q_W + 1;

   logic [STAGES-1:0] vld_ff, vld_in;
   alc_div_stage_type stg_ff [STAGES];
   alc_div_stage_type stg_in [STAGES];

   always_comb begin
      logic [DIVD_W:0] trial;
      logic            ge;
      vld_in = {vld_ff[STAGES-2:0], in_valid};

      // Setup: quotient of 2048 or more only needs a flag, not its bits
      stg_in[0].sat  = in_data.sat;
      stg_in[0].c0   = in_data.c0;
      stg_in[0].c1   = in_data.c1;
      stg_in[0].rem  = {in_data.c1, {RATIO_SH{1'b0}}};
      stg_in[0].quot = '0;
      stg_in[0].zero = (in_data.c0 == '0);
      stg_in[0].big  = ({1'b0, in_data.c1, {RATIO_SH{1'b0}}} >= {in_data.c0, {Q_W{1'b0}}});

      // One restoring step per stage, most significant quotient bit first
      for (int k = 1; k < STAGES; k++) begin
         trial = (DIVD_W + 1)'(stg_ff[k-1].c0) << (Q_W - k);
         ge    = ({1'b0, stg_ff[k-1].rem} >= trial);
         stg_in[k] = stg_ff[k-1];
         if (ge) begin
            stg_in[k].rem = DIVD_W'({1'b0, stg_ff[k-1].rem} - trial);
         end
         stg_in[k].quot = {stg_ff[k-1].quot[Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_ff <= stg_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_stage = stg_ff[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/alc_front.sv -----
`default_nettype none

module alc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  alc_pkg::alc_cfg_type        cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [alc_pkg::RAW_W-1:0]   req_broadband_count,
   input  logic [alc_pkg::RAW_W-1:0]   req_infrared_count,
   input  alc_pkg::alc_q_stat_type     q_stat,
   output logic                        q_push,
   output alc_pkg::alc_item_type       q_item
);
   import alc_pkg::*;

   localparam int MUL_W = SCALE_W + RAW_W;

   logic              adv;
   logic [BASE_W-1:0] scale_base;
   logic [SCALE_W-1:0] scale;
   logic [MUL_W-1:0]  prod0, prod1;
   logic              a_valid_ff, a_valid_in;
   alc_scaled_type    a_data_ff, a_data_in;
   logic              div_valid;
   alc_div_stage_type div_out;
   logic [Q_W:0]      ratio_sum;
   logic [Q_W-1:0]    ratio;
   logic [SEG_W-1:0]  seg;

   // Hold the whole front while a finished request waits on a full queue
   assign adv       = !(div_valid && q_stat.full);
   assign req_ready = adv;

   always_comb begin
      case (cfg.integ_sel)
         INTEG_13MS:  scale_base = SCALE_13MS;
         INTEG_101MS: scale_base = SCALE_101MS;
         default:     scale_base = SCALE_UNITY;
      endcase
      scale = cfg.gain_16x ? SCALE_W'(scale_base) : {scale_base, {GAIN_SHIFT{1'b0}}};
      prod0 = MUL_W'(req_broadband_count) * MUL_W'(scale);
      prod1 = MUL_W'(req_infrared_count) * MUL_W'(scale);

      a_valid_in    = req_valid;
      a_data_in.sat = (req_broadband_count == COUNT_FULL) ||
                      (req_infrared_count == COUNT_FULL);
      a_data_in.c0  = prod0[SCALE_FRAC +: SC_W];
      a_data_in.c1  = prod1[SCALE_FRAC +: SC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_data_ff <= a_data_in;
      end
   end

   alc_ratio_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (a_valid_ff),
      .in_data   (a_data_ff),
      .out_valid (div_valid),
      .out_stage (div_out)
   );

   // Round the ratio and pick the coefficient pair
   always_comb begin
      ratio_sum = {1'b0, div_out.quot} + (Q_W + 1)'(1);
      ratio     = div_out.zero ? '0 : ratio_sum[Q_W:1];
      seg       = alc_segment(cfg.pkg_cs, div_out.big && !div_out.zero, ratio);
      q_item.sat = div_out.sat;
      q_item.c0  = div_out.c0;
      q_item.c1  = div_out.c1;
      q_item.b   = BASE_TAB[cfg.pkg_cs][seg];
      q_item.m   = SLOPE_TAB[cfg.pkg_cs][seg];
   end

   assign q_push = div_valid && !q_stat.full;

endmodule

`default_nettype wire

// ----- rtl/alc_queue.sv -----
`default_nettype none

module alc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  alc_pkg::alc_item_type   push_item,
   input  logic                    pop,
   output alc_pkg::alc_item_type   head_item,
   output alc_pkg::alc_q_stat_type stat
);
   import alc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   alc_item_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == FILL_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ----- rtl/alc_back.sv -----
`default_nettype none

module alc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  alc_pkg::alc_q_stat_type   q_stat,
   input  alc_pkg::alc_item_type     q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [alc_pkg::LUX_W-1:0] rsp_lux_value,
   output logic                      rsp_saturated
);
   import alc_pkg::*;

   logic              adv;
   logic              p_valid_ff, p_valid_in;
   logic              p_sat_ff, p_sat_in;
   logic [PROD_W-1:0] p0_ff, p0_in;
   logic [PROD_W-1:0] p1_ff, p1_in;
   logic [PROD_W-1:0] diff, sum;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LUX_W-1:0]  rsp_lux_ff, rsp_lux_in;
   logic              rsp_sat_ff, rsp_sat_in;

   // Advance only when the response register is free or being taken
   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && !q_stat.empty;

   always_comb begin
      p_valid_in = !q_stat.empty;
      p_sat_in   = q_head.sat;
      p0_in      = PROD_W'(q_head.c0) * PROD_W'(q_head.b);
      p1_in      = PROD_W'(q_head.c1) * PROD_W'(q_head.m);

      // Clamp a negative difference or a saturated item to zero, then round off the fraction
      diff = p0_ff - p1_ff;
      sum  = diff + LUX_ROUND;
      rsp_valid_in = p_valid_ff;
      rsp_sat_in   = p_sat_ff;
      if (p_sat_ff || diff[PROD_W-1]) begin
         rsp_lux_in = '0;
      end else begin
         rsp_lux_in = sum[LUX_FRAC +: LUX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_sat_ff   <= p_sat_in;
         p0_ff      <= p0_in;
         p1_ff      <= p1_in;
         rsp_sat_ff <= rsp_sat_in;
         rsp_lux_ff <= rsp_lux_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lux_value = rsp_lux_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

`default_nettype wire

// ----- rtl/ambient_light_lux_calc.sv -----
// Illuminance calculator for a two-channel light sensor.
// Request channel (req_valid/req_ready) carries a broadband and an infrared
// count; response channel (rsp_valid/rsp_ready) returns whole lux and a
// saturation flag, one response per request, in request order.
// csr_wr_en/csr_index/csr_wdata write integration time (index 0), gain
// (index 1) and coefficient package (index 2); write them while idle.
// Throughput: one request per cycle while req_ready is high. On its way from
// acceptance to rsp_valid a request passes the scaling multiply, the ratio
// divider (one quotient bit per stage over 11 stages plus a setup stage), the
// queue write, the coefficient multiply and the response register.
// The front (scaling, divider, segment lookup) and the back (coefficient
// multiply, clamp and rounding) are joined by a QUEUE_DEPTH entry queue.
// When rsp_ready is low the back holds; the front keeps accepting until
// the queue fills, then drops req_ready.
// Reset clears all pipeline valids and the queue, and sets the registers
// to 402 ms integration, 1x gain and the T/FN/CL table.
`default_nettype none

module ambient_light_lux_calc #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [alc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [alc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [alc_pkg::RAW_W-1:0]      req_broadband_count,
   input  logic [alc_pkg::RAW_W-1:0]      req_infrared_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [alc_pkg::LUX_W-1:0]      rsp_lux_value,
   output logic                           rsp_saturated
);
   import alc_pkg::*;

   alc_cfg_type    cfg_ff, cfg_in;
   alc_q_stat_type q_stat;
   alc_item_type   push_item, head_item;
   logic           push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_INTEG: cfg_in.integ_sel = csr_wdata[1:0];
            CSR_GAIN:  cfg_in.gain_16x  = csr_wdata[0];
            CSR_PKG:   cfg_in.pkg_cs    = csr_wdata[0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integ_sel <= INTEG_402MS;
         cfg_ff.gain_16x  <= 1'b0;
         cfg_ff.pkg_cs    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   alc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_broadband_count (req_broadband_count),
      .req_infrared_count  (req_infrared_count),
      .q_stat              (q_stat),
      .q_push              (push),
      .q_item              (push_item)
   );

   alc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   alc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_head        (head_item),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_lux_value (rsp_lux_value),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

// ----- rtl/alc_checker.sv -----
`default_nettype none

module alc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [alc_pkg::LUX_W-1:0] rsp_lux_value,
   input logic                      rsp_saturated
);
   import alc_pkg::*;

   localparam logic [LUX_W-1:0] LUX_MAX = 18'd131072;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lux_value) &&
                                  $stable(rsp_saturated))
      else $error("response changed while stalled");

   a_sat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_lux_value == '0)
      else $error("saturated response carries nonzero lux");

   a_lux_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lux_value <= LUX_MAX)
      else $error("lux value out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind ambient_light_lux_calc alc_checker u_alc_checker (.*);

`default_nettype wire
